// ===== hw/rtl/mkht_pkg.sv =====
// Shared types and constants for the multiword-key hash table.
// No dependencies.
`default_nettype none
package mkht_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_COUNT  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  localparam logic [31:0] HASH_SEED      = 32'd5381;
  localparam logic [30:0] FREQ_MAX       = 31'h7FFF_FFFF;
  localparam logic [8:0]  COUNT_MAX      = 9'd511;
  localparam logic [3:0]  PROBE_LIM_RST  = 4'd8;

  // controller -> datapath
  typedef struct packed {
    logic       push;        // input transfer
    logic       start;       // last word: latch operation
    logic       set_status;
    logic [1:0] status_code;
    logic       probe_next;
    logic       word_next;
    logic       word_clear;
    logic       do_lookup;
    logic       do_remove;
    logic       copy_write;
    logic       ins_meta;
    logic       scan_step;
    logic       load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       too_long;
    logic       occ_full;
    logic       occ_empty;
    logic       slot_valid;
    logic       len_eq;
    logic       word_eq;
    logic       last_word;
    logic       last_probe;
    logic       last_scan;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/multiword_key_hash_table_unit.sv =====
// Top level of the multiword-key hash table (djb2 hash, linear probing).
// Depends on mkht_pkg, mkht_ctrl and mkht_datapath.
//
//  channel  handshake              payload
//  in       in_valid / in_stall    command key_word key_last entry_value
//                                  start_freq bump_freq threshold
//  out      out_valid / out_stall  status found_value found_freq entry_count
//  cfg      cfg_wr_en              cfg_wr_data (probe_limit)
//
// A non-last key word is added to the key accumulator. A last word runs
// the command: each probed slot passes a metadata read and check, and each
// compared or copied key word a read and a check or write (one registered
// read of the slot word store per word), so with eight probes and
// sixteen-word keys the walk dominates. Count sweeps every slot once
// through the frequency store. Reset (rst, synchronous) clears valid bits,
// occupancy and the key accumulator; no clearing pass. A held result
// blocks only the next result, not word transfers into the idle block.
`default_nettype none
module multiword_key_hash_table_unit #(
  parameter int TABLE_SLOTS   = 256,
  parameter int MAX_KEY_WORDS = 16,
  parameter int MAX_PROBES    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] key_word,
  input  wire logic        key_last,
  input  wire logic [31:0] entry_value,
  input  wire logic [30:0] start_freq,
  input  wire logic        bump_freq,
  input  wire logic [30:0] threshold,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      found_value,
  output logic [30:0]      found_freq,
  output logic [8:0]       entry_count
);

  mkht_pkg::ctrl_t ctl;
  mkht_pkg::stat_t st;

  // sequencer: walks probes, word compares, copies and the count sweep
  mkht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .key_last (key_last),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  // stores, hash, counters and the output register
  mkht_datapath #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS),
    .MAX_PROBES    (MAX_PROBES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .command     (command),
    .key_word    (key_word),
    .entry_value (entry_value),
    .start_freq  (start_freq),
    .bump_freq   (bump_freq),
    .threshold   (threshold),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value),
    .found_freq  (found_freq),
    .entry_count (entry_count),
    .ctl         (ctl),
    .st          (st)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/mkht_ctrl.sv =====
// Sequencer for the multiword-key hash table.
// Depends on mkht_pkg.
`default_nettype none
module mkht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          key_last,
  output logic               in_stall,
  input  wire mkht_pkg::stat_t st,
  output mkht_pkg::ctrl_t    ctl
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_DECIDE    = 14'b00000000000010,
    S_META_RD   = 14'b00000000000100,
    S_META_CHK  = 14'b00000000001000,
    S_CMP_RD    = 14'b00000000010000,
    S_CMP_CHK   = 14'b00000000100000,
    S_LOOKUP    = 14'b00000001000000,
    S_REMOVE    = 14'b00000010000000,
    S_COPY_RD   = 14'b00000100000000,
    S_COPY_WR   = 14'b00001000000000,
    S_INS_META  = 14'b00010000000000,
    S_SCAN      = 14'b00100000000000,
    S_SCAN_TAIL = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.push = 1'b1;
          if (key_last) begin
            ctl.start = 1'b1;
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        ctl.set_status = 1'b1;
        if (st.cmd == mkht_pkg::CMD_COUNT) begin
          if (st.occ_empty) begin
            ctl.status_code = mkht_pkg::ST_MISSING;
            state_next = S_DONE;
          end else begin
            ctl.status_code = mkht_pkg::ST_OK;
            state_next = S_SCAN;
          end
        end else if (st.too_long) begin
          ctl.status_code = mkht_pkg::ST_LONG;
          state_next = S_DONE;
        end else if (st.cmd == mkht_pkg::CMD_INSERT) begin
          ctl.status_code = mkht_pkg::ST_FULL;
          state_next = st.occ_full ? S_DONE : S_META_RD;
        end else begin
          ctl.status_code = mkht_pkg::ST_MISSING;
          state_next = S_META_RD;
        end
      end
      S_META_RD: state_next = S_META_CHK;
      S_META_CHK: begin
        if (st.cmd == mkht_pkg::CMD_INSERT && !st.slot_valid) begin
          state_next = S_COPY_RD;
        end else if (st.slot_valid && st.len_eq) begin
          state_next = S_CMP_RD;
        end else if (st.last_probe) begin
          state_next = S_DONE;
        end else begin
          ctl.probe_next = 1'b1;
          state_next = S_META_RD;
        end
      end
      S_CMP_RD: state_next = S_CMP_CHK;
      S_CMP_CHK: begin
        if (!st.word_eq) begin
          if (st.last_probe) begin
            state_next = S_DONE;
          end else begin
            ctl.probe_next = 1'b1;
            state_next = S_META_RD;
          end
        end else if (!st.last_word) begin
          ctl.word_next = 1'b1;
          state_next = S_CMP_RD;
        end else begin
          ctl.word_clear = 1'b1;
          case (st.cmd)
            mkht_pkg::CMD_INSERT: state_next = S_COPY_RD;
            mkht_pkg::CMD_LOOKUP: state_next = S_LOOKUP;
            default:              state_next = S_REMOVE;
          endcase
        end
      end
      S_LOOKUP: begin
        ctl.do_lookup = 1'b1;
        ctl.set_status = 1'b1;
        ctl.status_code = mkht_pkg::ST_OK;
        state_next = S_DONE;
      end
      S_REMOVE: begin
        ctl.do_remove = 1'b1;
        ctl.set_status = 1'b1;
        ctl.status_code = mkht_pkg::ST_OK;
        state_next = S_DONE;
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        ctl.copy_write = 1'b1;
        if (st.last_word) begin
          state_next = S_INS_META;
        end else begin
          ctl.word_next = 1'b1;
          state_next = S_COPY_RD;
        end
      end
      S_INS_META: begin
        ctl.ins_meta = 1'b1;
        ctl.set_status = 1'b1;
        ctl.status_code = mkht_pkg::ST_OK;
        state_next = S_DONE;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (st.last_scan) state_next = S_SCAN_TAIL;
      end
      S_SCAN_TAIL: state_next = S_DONE;
      S_DONE: begin
        if (st.out_free) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mkht_datapath.sv =====
// Datapath for the multiword-key hash table: key accumulator, hash,
// slot stores, probe/word/scan counters, result and output registers.
// Depends on mkht_pkg.
`default_nettype none
module mkht_datapath #(
  parameter int TABLE_SLOTS   = 256,
  parameter int MAX_KEY_WORDS = 16,
  parameter int MAX_PROBES    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [3:0]    cfg_wr_data,
  input  wire logic [1:0]    command,
  input  wire logic [31:0]   key_word,
  input  wire logic [31:0]   entry_value,
  input  wire logic [30:0]   start_freq,
  input  wire logic          bump_freq,
  input  wire logic [30:0]   threshold,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         status,
  output logic [31:0]        found_value,
  output logic [30:0]        found_freq,
  output logic [8:0]         entry_count,
  input  wire mkht_pkg::ctrl_t ctl,
  output mkht_pkg::stat_t    st
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int KW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int LW = $clog2(MAX_KEY_WORDS + 2);
  localparam int CW = $clog2(MAX_PROBES + 1);
  localparam int OW = $clog2(TABLE_SLOTS + 1);
  localparam int AW = $clog2(TABLE_SLOTS * MAX_KEY_WORDS);
  localparam int WORDS = TABLE_SLOTS * MAX_KEY_WORDS;

  // configuration
  logic [3:0] probe_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_limit <= mkht_pkg::PROBE_LIM_RST;
    end else if (cfg_wr_en) begin
      probe_limit <= cfg_wr_data;
    end
  end

  // key accumulator and hash
  logic [31:0] incoming_key [MAX_KEY_WORDS];
  logic [LW-1:0] inc_len, len_after;
  logic [31:0] running_hash, hash_after;

  assign len_after  = (32'(inc_len) < MAX_KEY_WORDS) ? inc_len + LW'(1) : LW'(MAX_KEY_WORDS + 1);
  assign hash_after = (running_hash << 5) + running_hash + key_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_len      <= '0;
      running_hash <= mkht_pkg::HASH_SEED;
    end else if (ctl.push) begin
      if (ctl.start) begin
        inc_len      <= '0;
        running_hash <= mkht_pkg::HASH_SEED;
      end else begin
        inc_len      <= len_after;
        running_hash <= hash_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && 32'(inc_len) < MAX_KEY_WORDS) begin
      incoming_key[inc_len[KW-1:0]] <= key_word;
    end
  end

  // latched operation
  logic [1:0]    op_cmd;
  logic [LW-1:0] op_len;
  logic [SW-1:0] home;
  logic [31:0]   op_value;
  logic [30:0]   op_sfreq, op_thr;
  logic          op_bump;
  logic [CW-1:0] n_probes, n_probes_next;

  always_comb begin
    if (probe_limit == 4'd0) begin
      n_probes_next = CW'(1);
    end else if (32'(probe_limit) > MAX_PROBES) begin
      n_probes_next = CW'(MAX_PROBES);
    end else begin
      n_probes_next = CW'(probe_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_cmd   <= command;
      op_len   <= len_after;
      home     <= hash_after[SW-1:0];
      op_value <= entry_value;
      op_sfreq <= start_freq;
      op_thr   <= threshold;
      op_bump  <= bump_freq;
      n_probes <= n_probes_next;
    end
  end

  // probe and word counters
  logic [CW-1:0] probe_i;
  logic [KW-1:0] word_j;
  logic [SW-1:0] slot;
  logic [AW-1:0] word_addr;

  assign slot      = home + SW'(probe_i);
  assign word_addr = AW'(32'(slot) * MAX_KEY_WORDS + 32'(word_j));

  always_ff @(posedge clk) begin
    if (ctl.start || ctl.probe_next) begin
      probe_i <= ctl.start ? '0 : probe_i + CW'(1);
    end
    if (ctl.start || ctl.probe_next || ctl.word_clear) begin
      word_j <= '0;
    end else if (ctl.word_next) begin
      word_j <= word_j + KW'(1);
    end
  end

  // slot stores
  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [LW-1:0] slot_key_len [TABLE_SLOTS];
  logic [31:0]   slot_value   [TABLE_SLOTS];
  logic [30:0]   slot_freq    [TABLE_SLOTS];
  logic [31:0]   slot_key_words [WORDS];
  logic [OW-1:0] occupancy;

  logic [LW-1:0] len_q;
  logic [31:0]   val_q, sk_q, ik_q;
  logic [30:0]   freq_q, bumped;
  logic [SW-1:0] scan_idx, freq_addr;
  logic          scan_live, scan_vld;

  assign freq_addr = ctl.scan_step ? scan_idx : slot;
  assign bumped    = (freq_q == mkht_pkg::FREQ_MAX) ? freq_q : freq_q + 31'd1;

  always_ff @(posedge clk) begin
    len_q <= slot_key_len[slot];
    val_q <= slot_value[slot];
    if (ctl.ins_meta) begin
      slot_key_len[slot] <= op_len;
      slot_value[slot]   <= op_value;
    end
  end

  always_ff @(posedge clk) begin
    freq_q <= slot_freq[freq_addr];
    if (ctl.ins_meta) begin
      slot_freq[slot] <= op_sfreq;
    end else if (ctl.do_lookup && op_bump) begin
      slot_freq[slot] <= bumped;
    end
  end

  always_ff @(posedge clk) begin
    sk_q <= slot_key_words[word_addr];
    if (ctl.copy_write) begin
      slot_key_words[word_addr] <= ik_q;
    end
  end

  always_ff @(posedge clk) begin
    ik_q <= incoming_key[word_j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      occupancy  <= '0;
    end else if (ctl.ins_meta) begin
      slot_valid[slot] <= 1'b1;
      if (!slot_valid[slot]) occupancy <= occupancy + OW'(1);
    end else if (ctl.do_remove) begin
      slot_valid[slot] <= 1'b0;
      if (occupancy != '0) occupancy <= occupancy - OW'(1);
    end
  end

  // results
  logic [1:0]  res_status;
  logic [31:0] res_value;
  logic [30:0] res_freq;
  logic [8:0]  res_count;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      scan_idx  <= '0;
      res_value <= '0;
      res_freq  <= '0;
      res_count <= '0;
    end else begin
      if (ctl.scan_step) scan_idx <= scan_idx + SW'(1);
      if (scan_live && scan_vld && freq_q >= op_thr && res_count < mkht_pkg::COUNT_MAX) begin
        res_count <= res_count + 9'd1;
      end
      if (ctl.do_lookup) begin
        res_value <= val_q;
        if (op_bump) res_freq <= bumped;
      end
    end
    scan_vld <= slot_valid[scan_idx];
    if (ctl.set_status) res_status <= ctl.status_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_live <= 1'b0;
    end else begin
      scan_live <= ctl.scan_step;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status      <= res_status;
      found_value <= res_value;
      found_freq  <= res_freq;
      entry_count <= res_count;
    end
  end

  // status to controller
  always_comb begin
    st.cmd        = op_cmd;
    st.too_long   = 32'(op_len) > MAX_KEY_WORDS;
    st.occ_full   = 32'(occupancy) >= TABLE_SLOTS / 2;
    st.occ_empty  = (occupancy == '0);
    st.slot_valid = slot_valid[slot];
    st.len_eq     = (len_q == op_len);
    st.word_eq    = (sk_q == ik_q);
    st.last_word  = (LW'(word_j) + LW'(1) == op_len);
    st.last_probe = (probe_i + CW'(1) == n_probes);
    st.last_scan  = (scan_idx == SW'(TABLE_SLOTS - 1));
    st.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire
